// File: hdl/rtt_pkg.sv
// Shared types and constants of the retry timeout table.
// No dependencies; retry_timeout_table_core and the testbench import it.
package rtt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int NEXT_W = 5;
   localparam int CNT_W = (IDX_W + 1 > NEXT_W) ? IDX_W + 1 : NEXT_W;

   localparam int ID_W = 20;
   localparam int ATT_W = 8;
   localparam int STAMP_W = 32;
   localparam int INTERVAL_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] CMD_RECORD = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_SCAN = 2'd2;

   localparam logic [2:0] KIND_RECORDED = 3'd0;
   localparam logic [2:0] KIND_FULL = 3'd1;
   localparam logic [2:0] KIND_REMOVED = 3'd2;
   localparam logic [2:0] KIND_PURGED = 3'd3;
   localparam logic [2:0] KIND_RETRY = 3'd4;
   localparam logic [2:0] KIND_NONE = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ATTEMPTS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOPPED = 2'd2;

   localparam logic [INTERVAL_W-1:0] RESET_INTERVAL = 16'd30;
   localparam logic [ATT_W-1:0] RESET_MAX_ATTEMPTS = 8'd5;

   typedef struct packed {
      logic [1:0] cmd;
      logic [ID_W-1:0] job_id;
      logic [STAMP_W-1:0] now;
      logic [NEXT_W-1:0] start_index;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [ID_W-1:0] out_job_id;
      logic [NEXT_W-1:0] next_index;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [ATT_W-1:0] attempts;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EVAL
   } state_type;

endpackage

// File: hdl/rtt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/retry_timeout_table_core.sv
// Top level of the retry timeout table: command sequencer, valid bits, config.
// Depends on rtt_pkg and rtt_ram (entry id, attempt count and time stamp).
//
//   channel  ports                              direction
//   req      req_valid req_ready req_data       in  (cmd, job_id, now, start_index)
//   rsp      rsp_valid rsp_ready rsp_data       out (kind, out_job_id, next_index, last)
//   csr      csr_valid csr_ready csr_index/wdata in (retry_interval, max_attempts, stopped)
//
// Record, unused command and stopped scan answer straight from idle. Remove and scan
// walk the table one slot at a time: a free slot is skipped in ST_WALK, a valid slot
// also passes ST_EVAL (one RAM read); a closing item or a retry ends the walk.
// Reset clears valid bits, state and output valid and loads the config defaults; no clearing pass.
// A single output register holds results; the walk holds while it is full and a result is due.
module retry_timeout_table_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  rtt_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rtt_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [rtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rtt_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [STAMP_W-1:0] now_ff, now_in;
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [ATT_W-1:0] max_att_ff, max_att_in;
   logic stopped_ff, stopped_in;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr;
   entry_type ram_wdata;
   entry_type ram_rdata;
   logic [IDX_W-1:0] idx_lo;
   logic free_found;
   logic [IDX_W-1:0] free_idx;
   logic out_free;
   logic [STAMP_W-1:0] age;

   assign idx_lo = idx_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign age = now_ff - ram_rdata.stamp;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   rtt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_ENTRIES)
   ) u_entry_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(idx_lo),
      .rd_data(ram_rdata)
   );

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd_in = cmd_ff;
      id_in = id_ff;
      now_in = now_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      interval_in = interval_ff;
      max_att_in = max_att_ff;
      stopped_in = stopped_ff;
      ram_we = 1'b0;
      ram_waddr = idx_lo;
      ram_wdata = '0;
      req_ready = (state_ff == ST_IDLE) && out_free;

      if (csr_valid) begin
         case (csr_index)
            CSR_RETRY_INTERVAL: interval_in = csr_wdata[INTERVAL_W-1:0];
            CSR_MAX_ATTEMPTS: max_att_in = csr_wdata[ATT_W-1:0];
            CSR_STOPPED: stopped_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in = req_data.cmd;
               id_in = req_data.job_id;
               now_in = req_data.now;
               rsp_data_in = '0;
               rsp_data_in.last = 1'b1;
               case (req_data.cmd)
                  CMD_RECORD: begin
                     rsp_valid_in = 1'b1;
                     if (free_found) begin
                        slot_valid_in[free_idx] = 1'b1;
                        ram_we = 1'b1;
                        ram_waddr = free_idx;
                        ram_wdata.id = req_data.job_id;
                        ram_wdata.attempts = '0;
                        ram_wdata.stamp = req_data.now;
                        rsp_data_in.kind = KIND_RECORDED;
                     end else begin
                        rsp_data_in.kind = KIND_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     idx_in = '0;
                     state_in = ST_WALK;
                  end
                  CMD_SCAN: begin
                     if (stopped_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in.kind = KIND_NONE;
                        rsp_data_in.next_index = req_data.start_index;
                     end else begin
                        idx_in = CNT_W'(req_data.start_index);
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in.kind = KIND_NONE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (idx_ff >= CNT_W'(TABLE_ENTRIES)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in = '0;
                  rsp_data_in.last = 1'b1;
                  if (cmd_ff == CMD_REMOVE) begin
                     rsp_data_in.kind = KIND_REMOVED;
                  end else begin
                     rsp_data_in.kind = KIND_NONE;
                     rsp_data_in.next_index = idx_ff[NEXT_W-1:0];
                  end
                  state_in = ST_IDLE;
               end
            end else if (!slot_valid_ff[idx_lo]) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (cmd_ff == CMD_REMOVE) begin
               if (ram_rdata.id == id_ff) begin
                  slot_valid_in[idx_lo] = 1'b0;
               end
               idx_in = idx_ff + CNT_W'(1);
               state_in = ST_WALK;
            end else if (age <= STAMP_W'(interval_ff)) begin
               idx_in = idx_ff + CNT_W'(1);
               state_in = ST_WALK;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.out_job_id = ram_rdata.id;
               rsp_data_in.next_index = idx_ff[NEXT_W-1:0];
               if (ram_rdata.attempts >= max_att_ff) begin
                  slot_valid_in[idx_lo] = 1'b0;
                  rsp_data_in.kind = KIND_PURGED;
                  rsp_data_in.last = 1'b0;
                  idx_in = idx_ff + CNT_W'(1);
                  state_in = ST_WALK;
               end else begin
                  ram_we = 1'b1;
                  ram_wdata.id = ram_rdata.id;
                  ram_wdata.attempts = ram_rdata.attempts + ATT_W'(1);
                  ram_wdata.stamp = now_ff;
                  rsp_data_in.kind = KIND_RETRY;
                  rsp_data_in.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         interval_ff <= RESET_INTERVAL;
         max_att_ff <= RESET_MAX_ATTEMPTS;
         stopped_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         interval_ff <= interval_in;
         max_att_ff <= max_att_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
      id_ff <= id_in;
      now_ff <= now_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: sim/tb_retry_timeout_table_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for retry_timeout_table_core: directed and random command
// traffic through a behavioral copy of the retry table. Depends on rtt_pkg and the core.
module tb_retry_timeout_table_core;
   import rtt_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [ID_W-1:0] TWIN_ID = 20'h5A5A5;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   retry_timeout_table_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [INTERVAL_W-1:0] cfg_interval = RESET_INTERVAL;
   logic [ATT_W-1:0] cfg_max_tries = RESET_MAX_ATTEMPTS;
   logic cfg_stopped = 1'b0;

   logic slot_used [TABLE_ENTRIES];
   logic [ID_W-1:0] slot_job [TABLE_ENTRIES];
   logic [ATT_W-1:0] slot_tries [TABLE_ENTRIES];
   logic [STAMP_W-1:0] slot_stamp [TABLE_ENTRIES];

   rsp_type results_due [$];
   logic [NEXT_W-1:0] scan_resume = '0;
   logic [STAMP_W-1:0] wall_now;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count = 0;
   bit req_up = 1'b0;

   initial begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
         slot_used[k] = 1'b0;
      end
   end

   function automatic void log_error(input string what);
      error_count++;
      if (error_count <= 10) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
   endfunction

   function automatic void add_due_result(input rsp_type r);
      results_due = {results_due, r};
   endfunction

   function automatic void step_retry_table(input req_type item);
      rsp_type r;
      int slot;
      logic [STAMP_W-1:0] age;
      bit done;
      r = '0;
      r.last = 1'b1;
      case (item.cmd)
         CMD_RECORD: begin
            r.kind = KIND_FULL;
            for (slot = 0; slot < TABLE_ENTRIES && r.kind == KIND_FULL; slot++) begin
               if (!slot_used[slot]) begin
                  slot_used[slot] = 1'b1;
                  slot_job[slot] = item.job_id;
                  slot_tries[slot] = '0;
                  slot_stamp[slot] = item.now;
                  r.kind = KIND_RECORDED;
               end
            end
            add_due_result(r);
         end
         CMD_REMOVE: begin
            for (slot = 0; slot < TABLE_ENTRIES; slot++) begin
               if (slot_used[slot] && slot_job[slot] == item.job_id) begin
                  slot_used[slot] = 1'b0;
               end
            end
            r.kind = KIND_REMOVED;
            add_due_result(r);
         end
         CMD_SCAN: begin
            if (cfg_stopped) begin
               r.kind = KIND_NONE;
               r.next_index = item.start_index;
               add_due_result(r);
            end else begin
               done = 1'b0;
               for (slot = int'(item.start_index); slot < TABLE_ENTRIES && !done; slot++) begin
                  age = item.now - slot_stamp[slot];
                  if (slot_used[slot] && age > STAMP_W'(cfg_interval)) begin
                     r.out_job_id = slot_job[slot];
                     r.next_index = NEXT_W'(slot);
                     if (slot_tries[slot] >= cfg_max_tries) begin
                        slot_used[slot] = 1'b0;
                        r.kind = KIND_PURGED;
                        r.last = 1'b0;
                     end else begin
                        slot_tries[slot] = slot_tries[slot] + 1'b1;
                        slot_stamp[slot] = item.now;
                        r.kind = KIND_RETRY;
                        r.last = 1'b1;
                        done = 1'b1;
                        scan_resume = NEXT_W'(slot + 1);
                     end
                     add_due_result(r);
                  end
               end
               if (!done) begin
                  r.kind = KIND_NONE;
                  r.out_job_id = '0;
                  r.last = 1'b1;
                  r.next_index = (int'(item.start_index) > TABLE_ENTRIES) ?
                                 item.start_index : NEXT_W'(TABLE_ENTRIES);
                  scan_resume = '0;
                  add_due_result(r);
               end
            end
         end
         CMD_UNUSED: begin
            r.kind = KIND_NONE;
            add_due_result(r);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            log_error($sformatf("unexpected result: kind %0d id %05h next %0d last %0b",
                                rsp_data.kind, rsp_data.out_job_id, rsp_data.next_index,
                                rsp_data.last));
         end else begin
            want = results_due.pop_front();
            if (rsp_data.kind !== want.kind || rsp_data.out_job_id !== want.out_job_id ||
                rsp_data.next_index !== want.next_index || rsp_data.last !== want.last) begin
               log_error($sformatf({"result mismatch: expected kind %0d id %05h next %0d ",
                                    "last %0b, got kind %0d id %05h next %0d last %0b"},
                                   want.kind, want.out_job_id, want.next_index, want.last,
                                   rsp_data.kind, rsp_data.out_job_id, rsp_data.next_index,
                                   rsp_data.last));
            end
         end
      end
   end

   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         if (req_up) begin
            req_valid <= 1'b0;
            req_up = 1'b0;
         end
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_up = 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      step_retry_table(item);
   endtask

   task automatic drain_results;
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [INTERVAL_W-1:0] interval,
                             input logic [ATT_W-1:0] tries, input logic halt);
      logic [CSR_IDX_W-1:0] reg_idx [3];
      logic [CSR_DATA_W-1:0] reg_val [3];
      int k;
      drain_results();
      reg_idx = '{CSR_RETRY_INTERVAL, CSR_MAX_ATTEMPTS, CSR_STOPPED};
      reg_val = '{CSR_DATA_W'(interval), CSR_DATA_W'(tries), CSR_DATA_W'(halt)};
      for (k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_idx[k];
         csr_wdata <= reg_val[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_interval = interval;
      cfg_max_tries = tries;
      cfg_stopped = halt;
   endtask

   task automatic test_fill_and_full;
      req_type item;
      int k;
      for (k = 0; k < TABLE_ENTRIES + 1; k++) begin
         item.cmd = CMD_RECORD;
         item.start_index = NEXT_W'($urandom);
         item.job_id = ID_W'($urandom);
         item.now = STAMP_W'(100 + k);
         case (k)
            0: begin
               item.job_id = '0;
               item.now = '0;
            end
            1: begin
               item.job_id = '1;
               item.now = '1;
            end
            2, 3: item.job_id = TWIN_ID;
            default: ;
         endcase
         send_req(item);
      end
   endtask

   task automatic test_unused_and_remove;
      req_type item;
      item.cmd = CMD_UNUSED;
      item.job_id = '1;
      item.now = '1;
      item.start_index = '1;
      send_req(item);
      item.cmd = CMD_REMOVE;
      item.job_id = TWIN_ID;
      item.now = 32'd200;
      item.start_index = '0;
      send_req(item);
   endtask

   task automatic test_scan_bounds;
      req_type item;
      item.cmd = CMD_SCAN;
      item.job_id = '0;
      item.now = 32'd1000;
      item.start_index = '1;
      send_req(item);
      item.start_index = NEXT_W'(TABLE_ENTRIES);
      send_req(item);
      item.now = 32'h8000_0000;
      item.start_index = '0;
      send_req(item);
   endtask

   task automatic test_stopped_scan;
      req_type item;
      set_config(RESET_INTERVAL, RESET_MAX_ATTEMPTS, 1'b1);
      item.cmd = CMD_SCAN;
      item.job_id = '1;
      item.now = 32'h9000_0000;
      item.start_index = 5'd5;
      send_req(item);
   endtask

   task automatic test_purge_sweep;
      req_type item;
      set_config('0, '0, 1'b0);
      item.cmd = CMD_SCAN;
      item.job_id = '0;
      item.now = 32'h8000_0001;
      item.start_index = '0;
      send_req(item);
   endtask

   task automatic test_random_traffic(input logic [INTERVAL_W-1:0] interval,
                                      input logic [ATT_W-1:0] tries, input logic halt,
                                      input int count);
      req_type item;
      logic [ID_W-1:0] id_pool [8];
      int n;
      int pick;
      set_config(interval, tries, halt);
      for (n = 0; n < 8; n++) begin
         id_pool[n] = ID_W'($urandom);
      end
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(49);
         if (pick == 0) begin
            wall_now = $urandom;
         end else if (pick == 1) begin
            wall_now = wall_now - $urandom_range(64);
         end else begin
            wall_now = wall_now + $urandom_range(cfg_interval / 3 + 2);
         end
         item.now = wall_now;
         item.job_id = ($urandom_range(3) == 0) ? ID_W'($urandom) : id_pool[$urandom_range(7)];
         pick = $urandom_range(9);
         if (pick < 5) begin
            item.start_index = scan_resume;
         end else if (pick < 8) begin
            item.start_index = NEXT_W'($urandom_range(TABLE_ENTRIES - 1));
         end else begin
            item.start_index = NEXT_W'($urandom);
         end
         pick = $urandom_range(99);
         if (pick < 35) begin
            item.cmd = CMD_RECORD;
         end else if (pick < 52) begin
            item.cmd = CMD_REMOVE;
         end else if (pick < 97) begin
            item.cmd = CMD_SCAN;
         end else begin
            item.cmd = CMD_UNUSED;
         end
         send_req(item);
      end
   endtask

   initial begin
      wall_now = $urandom;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 18;
      recv_idle_pct = 66;
      test_fill_and_full();
      test_unused_and_remove();
      test_scan_bounds();
      test_stopped_scan();
      test_purge_sweep();
      test_random_traffic(RESET_INTERVAL, RESET_MAX_ATTEMPTS, 1'b0, 80);
      test_random_traffic('1, '1, 1'b0, 80);

      send_idle_pct = 66;
      recv_idle_pct = 18;
      test_random_traffic(INTERVAL_W'($urandom_range(1, 100)),
                          ATT_W'($urandom_range(1, 4)), 1'b0, 80);
      test_random_traffic('0, 8'd1, 1'b0, 80);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(INTERVAL_W'($urandom), ATT_W'($urandom_range(3)), 1'b1, 80);
      test_random_traffic(INTERVAL_W'($urandom_range(300)),
                          ATT_W'($urandom_range(8)), 1'b0, 80);

      drain_results();
      repeat (2 * TABLE_ENTRIES + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/rtt_pkg.sv
hdl/rtt_ram.sv
hdl/retry_timeout_table_core.sv
sim/tb_retry_timeout_table_core.sv
